[sv/zobrist_board_hash_macros.svh]
// Assertion macros shared by the Zobrist board hash RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ZOBRIST_BOARD_HASH_MACROS_SVH
`define ZOBRIST_BOARD_HASH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ZBH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zobrist_board_hash: implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ZBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zobrist_board_hash: next-cycle check failed");

`endif

[sv/zbh_pkg.sv]
// Constants and the xorshift step for the Zobrist board hash.
// Depends on nothing; used by zobrist_board_hash.
`default_nettype none

package zbh_pkg;

  // Reset value of the generator seed
  localparam logic [63:0] SEED_RESET = 64'd1070372;

  // Output multiplier of the xorshift64* generator, split in halves
  localparam logic [63:0] GEN_MULT = 64'd2685821657736338717;
  localparam logic [31:0] GEN_MULT_LO = GEN_MULT[31:0];
  localparam logic [31:0] GEN_MULT_HI = GEN_MULT[63:32];

  // Shift amounts of the generator step
  localparam int unsigned SHIFT_A = 12;
  localparam int unsigned SHIFT_B = 25;
  localparam int unsigned SHIFT_C = 27;

  // One xorshift64 state update
  function automatic logic [63:0] xs_step(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> SHIFT_A);
    t = t ^ (t << SHIFT_B);
    t = t ^ (t >> SHIFT_C);
    return t;
  endfunction

endpackage

`default_nettype wire

[sv/zobrist_board_hash.sv]
// Zobrist board hash: key table fill engine and streaming hash datapath.
// Depends on zbh_pkg and zobrist_board_hash_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one word per board square.
//   Output channel (out_valid_o / out_ready_i) gives one 64-bit hash word for
//   each input word marked last_square_i.
//   Configuration: cfg_we_i writes cfg_wdata_i as the generator seed.
// Throughput: one square per cycle, limited by the single read port of the
//   key table memory; a stalled output register holds the next last square.
// Output path: the second stage registers, then the output hash register.
// Reset and seed writes: the key table, then the side key, is refilled from
//   the xorshift64* generator, one entry per cycle through the registered
//   partial products, and input is held off until the side key is written.
//   A seed write also clears the hash accumulator.
// Stall: while out_ready_i is low with a hash waiting, squares keep flowing
//   until the next last square reaches the second stage, which then holds and
//   stops input until the waiting hash is taken.
`default_nettype none

`include "zobrist_board_hash_macros.svh"

module zobrist_board_hash #(
  parameter int SQUARE_COUNT = 64,
  parameter int PIECE_KEYS   = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [5:0]  square_index_i,
  input  wire logic        occupied_i,
  input  wire logic        piece_black_i,
  input  wire logic [2:0]  piece_kind_i,
  input  wire logic        white_to_move_i,
  input  wire logic        last_square_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      board_hash_o
);

  localparam int Depth    = SQUARE_COUNT * PIECE_KEYS;
  localparam int HalfKeys = PIECE_KEYS / 2;
  localparam int AW       = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW       = $clog2(Depth + 2);

  // Key table
  logic [63:0]   key_mem [Depth];
  logic [63:0]   side_key_q;

  // Fill engine
  logic          busy_q;
  logic [CW-1:0] issue_q;
  logic [63:0]   gen_q;
  logic [63:0]   gen_next;
  logic          issue_en;
  logic          ma_valid_q;
  logic [CW-1:0] ma_idx_q;
  logic [63:0]   p0_q;
  logic [31:0]   p1_q;
  logic [31:0]   p2_q;
  logic [31:0]   cross_sum;
  logic [63:0]   key_w;

  // Hash datapath
  logic          in_accept;
  logic          in_hit;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_data_q;
  logic          s1_valid_q;
  logic          s1_hit_q;
  logic          s1_last_q;
  logic          s1_wtm_q;
  logic          s1_fire;
  logic          out_free;
  logic [63:0]   acc_q;
  logic [63:0]   acc_sum;
  logic [63:0]   hash_w;
  logic          out_valid_q;
  logic [63:0]   board_hash_q;

  // Advance the generator while entries remain to be issued
  assign issue_en  = busy_q && (issue_q <= CW'(Depth));
  assign gen_next  = zbh_pkg::xs_step(gen_q);
  assign cross_sum = p1_q + p2_q;
  assign key_w     = p0_q + {cross_sum, 32'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q      <= zbh_pkg::SEED_RESET;
      busy_q     <= 1'b1;
      issue_q    <= '0;
      ma_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      gen_q      <= cfg_wdata_i;
      busy_q     <= 1'b1;
      issue_q    <= '0;
      ma_valid_q <= 1'b0;
    end else begin
      ma_valid_q <= issue_en;
      if (issue_en) begin
        gen_q   <= gen_next;
        issue_q <= issue_q + CW'(1);
      end
      if (ma_valid_q && (ma_idx_q == CW'(Depth))) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Partial products of the output multiply; the high-by-high term drops out
  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      ma_idx_q <= issue_q;
      p0_q     <= 64'(gen_next[31:0]) * 64'(zbh_pkg::GEN_MULT_LO);
      p1_q     <= 32'(gen_next[63:32] * zbh_pkg::GEN_MULT_LO);
      p2_q     <= 32'(gen_next[31:0] * zbh_pkg::GEN_MULT_HI);
    end
  end

  // Write finished keys; the entry after the table is the side key
  always_ff @(posedge clk_i) begin
    if (ma_valid_q && (ma_idx_q < CW'(Depth))) begin
      key_mem[ma_idx_q[AW-1:0]] <= key_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ma_valid_q && (ma_idx_q == CW'(Depth))) begin
      side_key_q <= key_w;
    end
  end

  // Decode the square word into a table address
  assign in_hit  = occupied_i && (int'(square_index_i) < SQUARE_COUNT) &&
                   (int'(piece_kind_i) < HalfKeys);
  assign rd_addr = AW'(int'(square_index_i) * PIECE_KEYS + int'(piece_kind_i) +
                       (piece_black_i ? HalfKeys : 0));

  // Second stage holds a last square while a full output register is not taken
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !busy_q && (!s1_valid_q || s1_fire);
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_accept && in_hit) begin
      rd_data_q <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_hit_q  <= in_hit;
      s1_last_q <= last_square_i;
      s1_wtm_q  <= white_to_move_i;
    end
  end

  // Fold the key into the accumulator and form the hash
  assign acc_sum = acc_q ^ (s1_hit_q ? rd_data_q : 64'b0);
  assign hash_w  = acc_sum ^ (s1_wtm_q ? side_key_q : 64'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        acc_q <= s1_last_q ? 64'b0 : acc_sum;
      end
      if (s1_fire && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      board_hash_q <= hash_w;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign board_hash_o = board_hash_q;

  // Checks on fill and stall interplay
  `ZBH_ASSERT_IMPLY(a_no_item_in_fill, clk_i, rst_ni, busy_q, !s1_valid_q)
  `ZBH_ASSERT_IMPLY(a_mult_only_in_fill, clk_i, rst_ni, ma_valid_q, busy_q)
  `ZBH_ASSERT_IMPLY(a_issue_bound, clk_i, rst_ni, busy_q, issue_q <= CW'(Depth + 1))
  `ZBH_ASSERT_NEXT(a_hold_last_on_stall, clk_i, rst_ni,
                   s1_valid_q && s1_last_q && out_valid_q && !out_ready_i && !cfg_we_i,
                   s1_valid_q && s1_last_q)

endmodule

`default_nettype wire
